### hw/rtl/i2cmbe_pkg.sv
// Shared types and constants for the I2C master bit engine.
package i2cmbe_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int BYTE_W      = 8;
    localparam int PHASE_W     = 5;

    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_TXACK = 3'd4,
        OP_RXACK = 3'd5
    } t_op;

    typedef struct packed {
        logic              cmd_ok;
        t_op               op;
        logic [BYTE_W-1:0] wb;
        logic              ackb;
        logic              sda;
    } t_tick;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              busy;
        logic              done;
        logic [BYTE_W-1:0] rd;
        logic              ack;
    } t_result;

endpackage

### hw/rtl/i2cmbe_fifo.sv
// Small register queue with push/full and pop/empty sides.
module i2cmbe_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push_ok;
    logic             w_pop_ok;

    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_push_ok = i_push && !o_full;
    assign w_pop_ok  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (w_push_ok) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_pop_ok) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_push_ok && !w_pop_ok) begin
            n_count = r_count + 1'b1;
        end else if (!w_push_ok && w_pop_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### hw/rtl/i2cmbe_front.sv
// Front end: accepts ticks, classifies the command and queues them.
module i2cmbe_front #(
    parameter int DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_push,
    output logic                            o_full,
    input  logic                            i_cmd_valid,
    input  logic [2:0]                      i_op,
    input  logic [i2cmbe_pkg::BYTE_W-1:0]   i_write_byte,
    input  logic                            i_ack_bit,
    input  logic                            i_sda_in,
    output i2cmbe_pkg::t_tick               o_tick,
    output logic                            o_tick_empty,
    input  logic                            i_tick_pop
);
    import i2cmbe_pkg::*;

    t_tick                w_tick;
    logic [$bits(t_tick)-1:0] w_tick_q;

    // Flag commands that can start; undefined ops never do.
    always_comb begin
        w_tick.cmd_ok = i_cmd_valid && (i_op <= 3'(OP_RXACK));
        w_tick.op     = t_op'(i_op);
        w_tick.wb     = i_write_byte;
        w_tick.ackb   = i_ack_bit;
        w_tick.sda    = i_sda_in;
    end

    i2cmbe_fifo #(
        .W     ($bits(t_tick)),
        .DEPTH (DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_tick),
        .o_full  (o_full),
        .i_pop   (i_tick_pop),
        .o_data  (w_tick_q),
        .o_empty (o_tick_empty)
    );

    assign o_tick = t_tick'(w_tick_q);

endmodule

### hw/rtl/i2cmbe_back.sv
// Back end: phase sequencer for SCL/SDA and the result queue.
module i2cmbe_back #(
    parameter int DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  i2cmbe_pkg::t_tick   i_tick,
    input  logic                i_tick_empty,
    output logic                o_tick_pop,
    output i2cmbe_pkg::t_result o_result,
    output logic                o_empty,
    input  logic                i_pop
);
    import i2cmbe_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_STOP  = 7'b0000100,
        S_WRITE = 7'b0001000,
        S_READ  = 7'b0010000,
        S_TXACK = 7'b0100000,
        S_RXACK = 7'b1000000
    } t_state;

    function automatic t_state op_state(input t_op op);
        t_state s;
        unique case (op)
            OP_START: s = S_START;
            OP_STOP:  s = S_STOP;
            OP_WRITE: s = S_WRITE;
            OP_READ:  s = S_READ;
            OP_TXACK: s = S_TXACK;
            OP_RXACK: s = S_RXACK;
            default:  s = S_IDLE;
        endcase
        return s;
    endfunction

    function automatic logic [PHASE_W-1:0] last_phase(input t_state s);
        logic [PHASE_W-1:0] p;
        unique case (s)
            S_START: p = PHASE_W'(3);
            S_STOP:  p = PHASE_W'(2);
            S_WRITE: p = PHASE_W'(23);
            S_READ:  p = PHASE_W'(16);
            S_TXACK: p = PHASE_W'(2);
            S_RXACK: p = PHASE_W'(2);
            default: p = '0;
        endcase
        return p;
    endfunction

    t_state             r_state, n_state, w_cur_state;
    logic [PHASE_W-1:0] r_phase, n_phase, w_cur_phase;
    logic [1:0]         r_sub, n_sub, w_cur_sub;
    logic [BYTE_W-1:0]  r_tx, n_tx, w_cur_tx;
    logic [BYTE_W-1:0]  r_rx, n_rx, w_cur_rx;
    logic               r_ack, n_ack;
    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic               w_busy, w_done;
    logic               w_res_full;
    t_result            w_res;
    logic [$bits(t_result)-1:0] w_res_q;

    assign o_tick_pop = !i_tick_empty && !w_res_full;

    always_comb begin
        w_cur_state = r_state;
        w_cur_phase = r_phase;
        w_cur_sub   = r_sub;
        w_cur_tx    = r_tx;
        w_cur_rx    = r_rx;
        // Start a command only from idle; drop it otherwise.
        if (r_state == S_IDLE && i_tick.cmd_ok) begin
            w_cur_state = op_state(i_tick.op);
            w_cur_phase = '0;
            w_cur_sub   = '0;
            if (i_tick.op == OP_WRITE) begin
                w_cur_tx = i_tick.wb;
            end
            if (i_tick.op == OP_READ) begin
                w_cur_rx = '0;
            end
        end

        n_state = w_cur_state;
        n_phase = w_cur_phase;
        n_sub   = w_cur_sub;
        n_tx    = w_cur_tx;
        n_rx    = w_cur_rx;
        n_ack   = r_ack;
        n_scl   = r_scl;
        n_sda   = r_sda;
        w_busy  = 1'b0;
        w_done  = 1'b0;

        unique case (w_cur_state)
            S_IDLE: begin
            end
            S_START: begin
                unique case (w_cur_phase[1:0])
                    2'd0:    n_sda = 1'b1;
                    2'd1:    n_scl = 1'b1;
                    2'd2:    n_sda = 1'b0;
                    default: n_scl = 1'b0;
                endcase
            end
            S_STOP: begin
                priority if (w_cur_phase == '0) begin
                    n_sda = 1'b0;
                end else if (w_cur_phase == PHASE_W'(1)) begin
                    n_scl = 1'b1;
                end else begin
                    n_sda = 1'b1;
                end
            end
            S_WRITE: begin
                // Data, clock high, clock low per bit; shift out MSB first.
                priority if (w_cur_sub == 2'd0) begin
                    n_sda = w_cur_tx[BYTE_W-1];
                    n_tx  = {w_cur_tx[BYTE_W-2:0], 1'b0};
                end else if (w_cur_sub == 2'd1) begin
                    n_scl = 1'b1;
                end else begin
                    n_scl = 1'b0;
                end
                n_sub = (w_cur_sub == 2'd2) ? 2'd0 : w_cur_sub + 2'd1;
            end
            S_READ: begin
                priority if (w_cur_phase == '0) begin
                    n_sda = 1'b1;
                end else if (w_cur_phase[0]) begin
                    n_scl = 1'b1;
                    n_rx  = {w_cur_rx[BYTE_W-2:0], i_tick.sda};
                end else begin
                    n_scl = 1'b0;
                end
            end
            S_TXACK: begin
                priority if (w_cur_phase == '0) begin
                    n_sda = i_tick.ackb;
                end else if (w_cur_phase == PHASE_W'(1)) begin
                    n_scl = 1'b1;
                end else begin
                    n_scl = 1'b0;
                end
            end
            S_RXACK: begin
                priority if (w_cur_phase == '0) begin
                    n_sda = 1'b1;
                end else if (w_cur_phase == PHASE_W'(1)) begin
                    n_scl = 1'b1;
                    n_ack = i_tick.sda;
                end else begin
                    n_scl = 1'b0;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_cur_state != S_IDLE) begin
            w_busy = 1'b1;
            if (w_cur_phase == last_phase(w_cur_state)) begin
                w_done  = 1'b1;
                n_state = S_IDLE;
                n_phase = '0;
            end else begin
                n_phase = w_cur_phase + 1'b1;
            end
        end

        w_res.scl  = n_scl;
        w_res.sda  = n_sda;
        w_res.busy = w_busy;
        w_res.done = w_done;
        w_res.rd   = n_rx;
        w_res.ack  = n_ack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= '0;
            r_sub   <= '0;
            r_tx    <= '0;
            r_rx    <= '0;
            r_ack   <= 1'b1;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
        end else if (o_tick_pop) begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_sub   <= n_sub;
            r_tx    <= n_tx;
            r_rx    <= n_rx;
            r_ack   <= n_ack;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
        end
    end

    i2cmbe_fifo #(
        .W     ($bits(t_result)),
        .DEPTH (DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (o_tick_pop),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (w_res_q),
        .o_empty (o_empty)
    );

    assign o_result = t_result'(w_res_q);

endmodule

### hw/rtl/i2c_master_bit_engine.sv
// I2C master bit engine: tick-driven SCL/SDA sequencer, top level.
//
// Usage: each transaction on the input side (push while full is low) is
// one tick: an optional command (i_cmd_valid, i_op, i_write_byte, i_ack_bit)
// and the SDA level seen during that tick (i_sda_in). Every tick yields
// exactly one result on the output side, read while empty is low and
// taken with pop: the SCL/SDA levels after the tick, busy and done flags,
// the byte assembled so far and the last received ack bit.
// A command starts only when the engine is idle and applies its first
// phase on the tick that carries it; commands on busy ticks are dropped.
// A tick is held in the input queue, and its result in the result queue.
// Throughput: one tick per clock while the result queue has room; the
// sequencer applies one phase per tick that it takes from the input queue.
// Input and result queues are P_QUEUE_DEPTH entries each; when the result
// side stops popping, the result queue fills, the sequencer holds, and
// full rises once the input queue is full as well.
// Reset (synchronous, active low) empties both queues, returns the
// sequencer to idle and releases both lines high, ack bit high.
module i2c_master_bit_engine #(
    parameter int P_QUEUE_DEPTH = i2cmbe_pkg::QUEUE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic                          i_cmd_valid,
    input  logic [2:0]                    i_op,
    input  logic [i2cmbe_pkg::BYTE_W-1:0] i_write_byte,
    input  logic                          i_ack_bit,
    input  logic                          i_sda_in,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_scl,
    output logic                          o_sda_out,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic [i2cmbe_pkg::BYTE_W-1:0] o_read_byte,
    output logic                          o_ack_received
);
    import i2cmbe_pkg::*;

    t_tick   w_tick;
    logic    w_tick_empty;
    logic    w_tick_pop;
    t_result w_result;

    i2cmbe_front #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd_valid  (i_cmd_valid),
        .i_op         (i_op),
        .i_write_byte (i_write_byte),
        .i_ack_bit    (i_ack_bit),
        .i_sda_in     (i_sda_in),
        .o_tick       (w_tick),
        .o_tick_empty (w_tick_empty),
        .i_tick_pop   (w_tick_pop)
    );

    i2cmbe_back #(
        .DEPTH (P_QUEUE_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_tick),
        .i_tick_empty (w_tick_empty),
        .o_tick_pop   (w_tick_pop),
        .o_result     (w_result),
        .o_empty      (empty),
        .i_pop        (pop)
    );

    assign o_scl          = w_result.scl;
    assign o_sda_out      = w_result.sda;
    assign o_busy_res     = w_result.busy;
    assign o_done_res     = w_result.done;
    assign o_read_byte    = w_result.rd;
    assign o_ack_received = w_result.ack;

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_pop_has_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tick_pop |-> !w_tick_empty)
        else $error("sequencer took a tick from an empty queue");

    a_done_is_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_done_res) |-> o_busy_res)
        else $error("done result without busy");

    a_empty_queue_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_tick_empty && !pop && empty) |=> empty)
        else $error("result appeared without a tick");

endmodule
